[src/itp_pkg.sv]
package itp_pkg;

  // Digit value that no radix accepts.
  localparam logic [5:0] NOT_A_DIGIT = 6'd36;

  // Depth of the queue between the classifier and the scanner.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NUMBER_BASE   = 2'd0;
  localparam logic [1:0] CFG_SIGNED_RESULT = 2'd1;
  localparam logic [1:0] CFG_WIDE_RESULT   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_BASE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_NUMBER,
    PH_ZERO,
    PH_XMARK,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // One classified character.
  typedef struct packed {
    logic [5:0] digit;
    logic       blank;
    logic       plus;
    logic       minus;
    logic       xmark;
    logic       zero;
    logic       last;
  } class_t;

  typedef struct packed {
    logic [5:0] number_base;
    logic       signed_result;
    logic       wide_result;
  } cfg_t;

endpackage

[src/itp_classify.sv]
module itp_classify (
  input  logic [7:0]      character,
  input  logic            last_char,
  output itp_pkg::class_t cls
);
  import itp_pkg::*;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  always_comb begin
    if (character inside {[CH_0:CH_9]}) begin
      cls.digit = 6'(character - CH_0);
    end else if (character inside {[CH_LA:CH_LZ]}) begin
      cls.digit = 6'(character - CH_LA + 8'd10);
    end else if (character inside {[CH_UA:CH_UZ]}) begin
      cls.digit = 6'(character - CH_UA + 8'd10);
    end else begin
      cls.digit = NOT_A_DIGIT;
    end
    cls.blank = (character == CH_SPACE) || (character inside {[CH_TAB:CH_CR]});
    cls.plus  = (character == CH_PLUS);
    cls.minus = (character == CH_MINUS);
    cls.xmark = (character == CH_LX) || (character == CH_UX);
    cls.zero  = (character == CH_0);
    cls.last  = last_char;
  end

endmodule

[src/itp_queue.sv]
module itp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_stall,
  input  itp_pkg::class_t push_data,
  output logic            pop_valid,
  input  logic            pop,
  output itp_pkg::class_t pop_data
);
  import itp_pkg::*;

  class_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push;

  assign push_stall = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign push       = push_valid && !push_stall;
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/itp_scan.sv]
module itp_scan #(
  parameter int MAX_TEXT_CHARS = 4095
) (
  input  logic            clk,
  input  logic            rst_n,
  input  itp_pkg::cfg_t   cfg,
  input  logic            item_valid,
  input  itp_pkg::class_t item,
  output logic            item_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     out_value,
  output logic [11:0]     out_end_offset,
  output logic [1:0]      out_status
);
  import itp_pkg::*;

  localparam int CW = $clog2(MAX_TEXT_CHARS + 1);

  // Per-text scan state.
  phase_t        phase_r, phase_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic          saw_r, saw_nxt;
  logic          ovf_r, ovf_nxt;
  logic [5:0]    base_r, base_nxt;
  logic [CW-1:0] cnt_r, cnt_inc;
  logic [CW-1:0] dend_r, dend_nxt;

  // Finishing stage: the state of a text whose last character was scanned.
  logic          fin_valid_r;
  logic [63:0]   fin_acc_r;
  logic          fin_neg_r;
  logic          fin_saw_r;
  logic          fin_ovf_r;
  logic [5:0]    fin_base_r;
  logic [CW-1:0] fin_dend_r;

  logic          out_valid_r;
  logic [63:0]   out_value_r, out_value_nxt;
  logic [11:0]   out_end_r, out_end_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic [5:0]    base_eff;
  logic          base_bad;
  logic          hex_zero;
  logic [5:0]    take_base;
  logic          digit_ok;
  logic [69:0]   mac;
  logic          mac_carry;
  logic          take;
  logic          lead_zero;
  logic          set_sign;
  logic          fin_adv;
  logic          fin_load;

  // The radix is latched from the register on the first character of a text.
  assign base_eff  = (cnt_r == '0) ? cfg.number_base : base_r;
  assign base_bad  = (base_eff == 6'd1) || (base_eff > 6'd36);
  assign hex_zero  = item.zero && ((base_eff == 6'd0) || (base_eff == 6'd16));
  assign cnt_inc   = (cnt_r < CW'(MAX_TEXT_CHARS)) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    case (phase_r)
      PH_XMARK:           take_base = 6'd16;
      PH_SPACE, PH_NUMBER: take_base = (base_eff == 6'd0) ? 6'd10 : base_eff;
      default:            take_base = base_eff;
    endcase
  end

  assign digit_ok  = (take_base >= 6'd2) && (item.digit < take_base);
  // A 64 by 6 bit multiply-add; any bit above 63 means the magnitude overflowed.
  assign mac       = 70'(acc_r) * 70'(take_base) + 70'(item.digit);
  assign mac_carry = (mac[69:64] != '0);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_SPACE, PH_NUMBER: begin
        if (phase_r == PH_SPACE && item.blank) begin
          phase_nxt = PH_SPACE;
        end else if (phase_r == PH_SPACE && (item.plus || item.minus)) begin
          phase_nxt = PH_NUMBER;
        end else if (base_bad) begin
          phase_nxt = PH_DONE;
        end else if (hex_zero) begin
          phase_nxt = PH_ZERO;
        end else begin
          phase_nxt = digit_ok ? PH_DIGITS : PH_DONE;
        end
      end
      PH_ZERO: begin
        if (item.xmark) begin
          phase_nxt = PH_XMARK;
        end else begin
          phase_nxt = digit_ok ? PH_DIGITS : PH_DONE;
        end
      end
      PH_XMARK, PH_DIGITS: begin
        phase_nxt = digit_ok ? PH_DIGITS : PH_DONE;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Actions on the datapath.
  always_comb begin
    take      = 1'b0;
    lead_zero = 1'b0;
    set_sign  = 1'b0;
    base_nxt  = base_eff;
    case (phase_r)
      PH_SPACE, PH_NUMBER: begin
        if (phase_r == PH_SPACE && item.blank) begin
          set_sign = 1'b0;
        end else if (phase_r == PH_SPACE && (item.plus || item.minus)) begin
          set_sign = 1'b1;
        end else if (!base_bad) begin
          if (hex_zero) begin
            lead_zero = 1'b1;
            base_nxt  = (base_eff == 6'd0) ? 6'd8 : base_eff;
          end else begin
            base_nxt = take_base;
            take     = digit_ok;
          end
        end
      end
      PH_ZERO: begin
        take = !item.xmark && digit_ok;
      end
      PH_XMARK: begin
        take = digit_ok;
        if (digit_ok) begin
          base_nxt = 6'd16;
        end
      end
      PH_DIGITS: begin
        take = digit_ok;
      end
      default: take = 1'b0;
    endcase

    neg_nxt  = set_sign ? item.minus : neg_r;
    ovf_nxt  = ovf_r || (take && mac_carry);
    saw_nxt  = saw_r || take || lead_zero;
    dend_nxt = (take || lead_zero) ? cnt_inc : dend_r;
    if (take) begin
      acc_nxt = (ovf_r || mac_carry) ? '1 : mac[63:0];
    end else if (lead_zero) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = acc_r;
    end
  end

  assign fin_adv  = fin_valid_r && (!out_valid_r || !out_stall);
  assign item_pop = item_valid && (!item.last || !fin_valid_r || fin_adv);
  assign fin_load = item_pop && item.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      saw_r   <= 1'b0;
      ovf_r   <= 1'b0;
      base_r  <= 6'd10;
      cnt_r   <= '0;
      dend_r  <= '0;
    end else if (item_pop) begin
      base_r <= base_nxt;
      if (item.last) begin
        phase_r <= PH_SPACE;
        acc_r   <= '0;
        neg_r   <= 1'b0;
        saw_r   <= 1'b0;
        ovf_r   <= 1'b0;
        cnt_r   <= '0;
        dend_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        saw_r   <= saw_nxt;
        ovf_r   <= ovf_nxt;
        cnt_r   <= cnt_inc;
        dend_r  <= dend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= fin_load || (fin_valid_r && !fin_adv);
      out_valid_r <= fin_adv || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_acc_r  <= acc_nxt;
      fin_neg_r  <= neg_nxt;
      fin_saw_r  <= saw_nxt;
      fin_ovf_r  <= ovf_nxt;
      fin_base_r <= base_nxt;
      fin_dend_r <= dend_nxt;
    end
    if (fin_adv) begin
      out_value_r  <= out_value_nxt;
      out_end_r    <= out_end_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // Result formatting: limits, saturation and negation for the chosen mode.
  logic [63:0]    mask;
  logic [63:0]    limit;
  logic [63:0]    val;
  logic [CW+11:0] dend_ext;

  assign dend_ext = {12'd0, fin_dend_r};

  always_comb begin
    mask = cfg.wide_result ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    if (cfg.signed_result) begin
      limit = cfg.wide_result ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
      if (fin_neg_r) begin
        limit = limit + 64'd1;
      end
    end else begin
      limit = mask;
    end

    val            = '0;
    out_end_nxt    = '0;
    out_status_nxt = ST_OK;
    if ((fin_base_r == 6'd1) || (fin_base_r > 6'd36)) begin
      out_status_nxt = ST_BAD_BASE;
    end else if (fin_saw_r) begin
      out_end_nxt = dend_ext[11:0];
      if (fin_ovf_r || (fin_acc_r > limit)) begin
        out_status_nxt = ST_RANGE;
        val = (cfg.signed_result && fin_neg_r) ? 64'd0 - limit : limit;
      end else begin
        val = fin_neg_r ? 64'd0 - fin_acc_r : fin_acc_r;
      end
    end
    out_value_nxt = val & mask;
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_end_offset = out_end_r;
  assign out_status     = out_status_r;

endmodule

[src/integer_text_parser_core.sv]
// Streaming text-to-integer parser with strtol semantics.
// Input channel: one text byte per beat on in_character, with in_last_char
// marking the final byte of a text. The block asserts in_stall only when its
// two-entry input queue is full. A beat of in_valid high and in_stall low is
// accepted.
// Output channel: one result beat per text (out_value, out_end_offset,
// out_status), held stable while out_stall is high.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 radix,
// 1 signed mode, 2 64-bit mode); write only while no text is in flight.
// Throughput is one byte per cycle while the output is not stalled: each byte
// costs one pass through the scanner's 64 by 6 bit multiply-add. out_valid
// rises once the last byte has passed from the queue through the scanner's
// finishing stage into the result formatting register.
// A stalled receiver first fills the output register, then the formatting
// stage, after which texts stop at their last byte and the queue fills.
// Reset is synchronous: the queue empties, all pending results are dropped,
// and the registers return to radix 10, signed, 64-bit.
module integer_text_parser_core #(
  parameter int MAX_TEXT_CHARS = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic [11:0] out_end_offset,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import itp_pkg::*;

  cfg_t   cfg_r;
  class_t in_cls;
  class_t q_item;
  logic   q_valid;
  logic   q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.number_base   <= 6'd10;
      cfg_r.signed_result <= 1'b1;
      cfg_r.wide_result   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUMBER_BASE:   cfg_r.number_base   <= cfg_data;
        CFG_SIGNED_RESULT: cfg_r.signed_result <= cfg_data[0];
        CFG_WIDE_RESULT:   cfg_r.wide_result   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  itp_classify u_classify (
    .character (in_character),
    .last_char (in_last_char),
    .cls       (in_cls)
  );

  itp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (in_cls),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_item)
  );

  itp_scan #(
    .MAX_TEXT_CHARS (MAX_TEXT_CHARS)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .item_valid     (q_valid),
    .item           (q_item),
    .item_pop       (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_end_offset (out_end_offset),
    .out_status     (out_status)
  );

endmodule
